// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the walker RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Types, codes and field widths of the four-level page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

   localparam int PaWidth    = 52;
   localparam int VaWidth    = 48;
   localparam int PteWidth   = 64;
   localparam int KindWidth  = 2;
   localparam int SizeWidth  = 2;
   localparam int LevelWidth = 2;
   localparam int IdxWidth   = 9;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // register indexes (word address = paddr[2])
   localparam logic REG_WALKER_ENABLE = 1'b0;

   // operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_ENTRY = 1'b1;

   // entry bits
   localparam int PTE_PRESENT = 0;
   localparam int PTE_USER    = 2;
   localparam int PTE_LARGE   = 7;

   // walk levels: table whose entry is awaited
   localparam logic [LevelWidth-1:0] LEVEL_TOP  = 2'd3;
   localparam logic [LevelWidth-1:0] LEVEL_GIB  = 2'd2;
   localparam logic [LevelWidth-1:0] LEVEL_MIB  = 2'd1;
   localparam logic [LevelWidth-1:0] LEVEL_LEAF = 2'd0;

   typedef enum logic [KindWidth-1:0] {
      KIND_READ   = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_REJECT = 2'd2
   } result_kind_type;

   typedef enum logic [SizeWidth-1:0] {
      SIZE_4K = 2'd0,
      SIZE_2M = 2'd1,
      SIZE_1G = 2'd2
   } mapping_size_type;

   typedef struct packed {
      result_kind_type     kind;
      logic [PaWidth-1:0]  read_address;
      logic [PaWidth-1:0]  physical_address;
      logic                mapped;
      logic                user_accessible;
      mapping_size_type    mapping_size;
   } result_type;

   // nine-bit table index of a virtual address at a level
   function automatic logic [IdxWidth-1:0] entry_index(
      input logic [VaWidth-1:0]    va,
      input logic [LevelWidth-1:0] level
   );
      logic [IdxWidth-1:0] idx;
      case (level)
         LEVEL_TOP: idx = va[47:39];
         LEVEL_GIB: idx = va[38:30];
         LEVEL_MIB: idx = va[29:21];
         default:   idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

// ===== hdl/ptw_if.sv =====
// ----------------------------------------------------------------------------
// ptw_if
// Valid/ready channels of the walker: request side and response side.
// ----------------------------------------------------------------------------
interface ptw_req_if;
   logic                           valid;
   logic                           ready;
   logic                           operation;
   logic [ptw_pkg::PaWidth-1:0]    root_table_address;
   logic [ptw_pkg::VaWidth-1:0]    virtual_address;
   logic [ptw_pkg::PteWidth-1:0]   table_entry;

   modport source (output valid, operation, root_table_address, virtual_address,
                   table_entry, input ready);
   modport sink   (input valid, operation, root_table_address, virtual_address,
                   table_entry, output ready);
endinterface

interface ptw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ptw_pkg::KindWidth-1:0]  result_kind;
   logic [ptw_pkg::PaWidth-1:0]    read_address;
   logic [ptw_pkg::PaWidth-1:0]    physical_address;
   logic                           mapped;
   logic                           user_accessible;
   logic [ptw_pkg::SizeWidth-1:0]  page_size_code;

   modport source (output valid, result_kind, read_address, physical_address,
                   mapped, user_accessible, page_size_code, input ready);
   modport sink   (input valid, result_kind, read_address, physical_address,
                   mapped, user_accessible, page_size_code, output ready);
endinterface

// ===== hdl/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// x86-64 style four-level page-table walker, one transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
// Every transaction on req_chan (a walk start or a returned table entry)
// produces exactly one transaction on rsp_chan: a read request for the next
// entry, a finished walk (physical address, mapped, user, page size), or a
// reject for a start while busy or an entry while idle. A transaction is
// accepted every cycle as long as rsp_chan keeps up. The response side is a
// two-entry stage (output register plus skid register), so req_chan.ready
// only drops after two responses back up; that stage is what bounds
// throughput. The walker_enable register (APB, byte address 0) resets to 0
// and must be set before walks can succeed; write it only while the walker
// is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module four_level_page_table_walker (
   input  logic                                clock,
   input  logic                                reset,
   ptw_req_if.sink                             req_chan,
   ptw_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptw_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [ptw_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [ptw_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);

   // ---------------------------------------------------------------- CSR ---
   logic enable_ff, enable_in;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      enable_in = enable_ff;
      if (csr_write && csr_paddr[2] == ptw_pkg::REG_WALKER_ENABLE) begin
         enable_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == ptw_pkg::REG_WALKER_ENABLE) begin
         csr_prdata[0] = enable_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // ---------------------------------------------------------- walk state ---
   logic                                 busy_ff, busy_in;
   logic [ptw_pkg::LevelWidth-1:0]       level_ff, level_in;
   logic [ptw_pkg::VaWidth-1:0]          va_ff, va_in;
   logic                                 user_ff, user_in;

   logic                                 accept;
   ptw_pkg::result_type                  res;

   // entry fields
   logic                                 pte_present, pte_user, pte_large;
   logic                                 user_acc;
   logic [ptw_pkg::PteWidth-1:0]         pte;
   logic [ptw_pkg::LevelWidth-1:0]       next_level;

   assign pte         = req_chan.table_entry;
   assign pte_present = pte[ptw_pkg::PTE_PRESENT];
   assign pte_user    = pte[ptw_pkg::PTE_USER];
   assign pte_large   = pte[ptw_pkg::PTE_LARGE];
   assign user_acc    = user_ff & pte_user;
   assign next_level  = level_ff - 2'd1;

   // One pass: decide the response and the next walk state for the
   // transaction at the input.
   always_comb begin
      busy_in  = busy_ff;
      level_in = level_ff;
      va_in    = va_ff;
      user_in  = user_ff;

      res.kind             = ptw_pkg::KIND_DONE;
      res.read_address     = '0;
      res.physical_address = '0;
      res.mapped           = 1'b0;
      res.user_accessible  = 1'b0;
      res.mapping_size     = ptw_pkg::SIZE_4K;

      if (req_chan.operation == ptw_pkg::OP_START) begin
         if (busy_ff) begin
            res.kind = ptw_pkg::KIND_REJECT;
         end else if (!enable_ff || req_chan.root_table_address == '0) begin
            busy_in = 1'b0;     // finished, not mapped
         end else begin
            busy_in  = 1'b1;
            level_in = ptw_pkg::LEVEL_TOP;
            va_in    = req_chan.virtual_address;
            user_in  = 1'b1;
            res.kind = ptw_pkg::KIND_READ;
            // low 12 bits of root dropped; index*8 fits in them, no carry
            res.read_address = {req_chan.root_table_address[51:12],
                                ptw_pkg::entry_index(req_chan.virtual_address,
                                                     ptw_pkg::LEVEL_TOP),
                                3'b000};
         end
      end else begin
         if (!busy_ff) begin
            res.kind = ptw_pkg::KIND_REJECT;
         end else if (!enable_ff || !pte_present) begin
            busy_in = 1'b0;
         end else begin
            user_in = user_acc;
            if (level_ff == ptw_pkg::LEVEL_GIB && pte_large) begin
               busy_in              = 1'b0;
               res.physical_address = {pte[51:30], va_ff[29:0]};
               res.mapped           = 1'b1;
               res.user_accessible  = user_acc;
               res.mapping_size     = ptw_pkg::SIZE_1G;
            end else if (level_ff == ptw_pkg::LEVEL_MIB && pte_large) begin
               busy_in              = 1'b0;
               res.physical_address = {pte[51:21], va_ff[20:0]};
               res.mapped           = 1'b1;
               res.user_accessible  = user_acc;
               res.mapping_size     = ptw_pkg::SIZE_2M;
            end else if (level_ff == ptw_pkg::LEVEL_LEAF) begin
               busy_in              = 1'b0;
               res.physical_address = {pte[51:12], va_ff[11:0]};
               res.mapped           = 1'b1;
               res.user_accessible  = user_acc;
               res.mapping_size     = ptw_pkg::SIZE_4K;
            end else begin
               // table pointer (large bit ignored at the top level)
               level_in         = next_level;
               res.kind         = ptw_pkg::KIND_READ;
               res.read_address = {pte[51:12],
                                   ptw_pkg::entry_index(va_ff, next_level),
                                   3'b000};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         level_ff <= ptw_pkg::LEVEL_LEAF;
         va_ff    <= '0;
         user_ff  <= 1'b1;
      end else if (accept) begin
         busy_ff  <= busy_in;
         level_ff <= level_in;
         va_ff    <= va_in;
         user_ff  <= user_in;
      end
   end

   // ------------------------------------------------ response stage -------
   // Output register plus a skid register; input stalls only when the skid
   // register is full.
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   ptw_pkg::result_type  out_ff, out_in;
   ptw_pkg::result_type  skid_ff, skid_in;
   logic                 pop;

   assign req_chan.ready = ~skid_valid_ff;
   assign accept         = req_chan.valid & req_chan.ready;
   assign pop            = out_valid_ff & rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.result_kind      = out_ff.kind;
   assign rsp_chan.read_address     = out_ff.read_address;
   assign rsp_chan.physical_address = out_ff.physical_address;
   assign rsp_chan.mapped           = out_ff.mapped;
   assign rsp_chan.user_accessible  = out_ff.user_accessible;
   assign rsp_chan.page_size_code   = out_ff.mapping_size;

   // ----------------------------------------------------------- checks ----
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_read_leaves_busy, clock, reset, accept && res.kind == ptw_pkg::KIND_READ, busy_ff)
   `ASSERT_NEXT(a_done_leaves_idle, clock, reset, accept && res.kind == ptw_pkg::KIND_DONE, !busy_ff)
   `ASSERT_IMPLIES(a_top_user_set, clock, reset, busy_ff && level_ff == ptw_pkg::LEVEL_TOP, user_ff)
   `ASSERT_IMPLIES(a_mapped_only_done, clock, reset, out_valid_ff && out_ff.mapped, out_ff.kind == ptw_pkg::KIND_DONE)

endmodule
